[hdl/qte_pkg.sv]
// Shared types, widths and constants for the quaternion to Euler angle pipeline.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package qte_pkg;

    // Field and datapath widths.
    localparam int QW        = 32;  // quaternion component, Q30
    localparam int PW        = 34;  // one Q30 product after the shift
    localparam int SW        = 36;  // doubled sums and differences of products
    localparam int XYW       = 40;  // CORDIC x and y, with room for the gain
    localparam int ZW        = 33;  // CORDIC angle accumulator, Q30 radians
    localparam int SQW       = 61;  // square root radicand, up to 2^60
    localparam int RTW       = 31;  // square root result
    localparam int SQ_STAGES = 31;  // one root bit per stage
    localparam int ANGW      = 25;  // atan2 angle, Q16 degrees
    localparam int ROLLW     = 24;  // asin angle, Q16 degrees

    localparam logic signed [ANGW-1:0]  DEG180      = 25'sd11796480;
    localparam logic signed [ANGW-1:0]  DEG90       = 25'sd5898240;
    localparam logic signed [ROLLW-1:0] ROLL_LIM    = 24'sd5898240;
    localparam logic signed [30:0]      RAD2DEG_Q24 = 31'sd961263669;

    // Advance enable and the valid bit that enters a pipeline section.
    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

    // Operands that leave the product section for the three angle lanes.
    typedef struct packed {
        logic signed [SW-1:0] roll_y;
        logic                 sat_pos;
        logic                 sat_neg;
        logic signed [SW-1:0] pitch_y;
        logic signed [SW-1:0] pitch_x;
        logic signed [SW-1:0] yaw_y;
        logic signed [SW-1:0] yaw_x;
    } lanes_t;

    // atan(2^-i) in Q30 radians for each CORDIC stage.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd843314857;
            5'd1:    val = 30'd497837829;
            5'd2:    val = 30'd263043837;
            5'd3:    val = 30'd133525159;
            5'd4:    val = 30'd67021687;
            5'd5:    val = 30'd33543516;
            5'd6:    val = 30'd16775851;
            5'd7:    val = 30'd8388437;
            5'd8:    val = 30'd4194283;
            5'd9:    val = 30'd2097149;
            5'd10:   val = 30'd1048576;
            5'd11:   val = 30'd524288;
            5'd12:   val = 30'd262144;
            5'd13:   val = 30'd131072;
            5'd14:   val = 30'd65536;
            5'd15:   val = 30'd32768;
            5'd16:   val = 30'd16384;
            5'd17:   val = 30'd8192;
            5'd18:   val = 30'd4096;
            5'd19:   val = 30'd2048;
            5'd20:   val = 30'd1024;
            5'd21:   val = 30'd512;
            5'd22:   val = 30'd256;
            5'd23:   val = 30'd128;
            5'd24:   val = 30'd64;
            5'd25:   val = 30'd32;
            5'd26:   val = 30'd16;
            5'd27:   val = 30'd8;
            5'd28:   val = 30'd4;
            5'd29:   val = 30'd2;
            5'd30:   val = 30'd1;
            5'd31:   val = 30'd1;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[hdl/qte_if.sv]
// Valid/ready channel interfaces for the quaternion input and the angle output.
// Depends on qte_pkg for the field widths.
`default_nettype none

interface qte_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [qte_pkg::QW-1:0] quat_w;
    logic signed [qte_pkg::QW-1:0] quat_x;
    logic signed [qte_pkg::QW-1:0] quat_y;
    logic signed [qte_pkg::QW-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [qte_pkg::ROLLW-1:0] roll_deg;
    logic signed [qte_pkg::ANGW-1:0]  pitch_deg;
    logic signed [qte_pkg::ANGW-1:0]  yaw_deg;

    modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
    modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

`default_nettype wire

[hdl/qte_prod.sv]
// Product section: ten Q30 products, the rotation matrix terms and the asin radicand.
// Four register stages; depends on qte_pkg.
`default_nettype none

module qte_prod (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qte_pkg::pipe_ctl_t                 ctl,
    input  logic signed [qte_pkg::QW-1:0]      quat_w,
    input  logic signed [qte_pkg::QW-1:0]      quat_x,
    input  logic signed [qte_pkg::QW-1:0]      quat_y,
    input  logic signed [qte_pkg::QW-1:0]      quat_z,
    output logic                               vld,
    output qte_pkg::lanes_t                    lanes,
    output logic        [qte_pkg::SQW-1:0]     rem
);

    localparam int QW  = qte_pkg::QW;
    localparam int PW  = qte_pkg::PW;
    localparam int SW  = qte_pkg::SW;
    localparam int SQW = qte_pkg::SQW;
    localparam logic [SQW-1:0] SQ_ONE = 61'h1000_0000_0000_0000;
    localparam logic signed [SW-1:0] S_ONE = 36'sd1073741824;

    // Exact product shifted right by 30, rounding toward minus infinity.
    function automatic logic signed [PW-1:0] mul_q30(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic signed [63:0] m;
        m = 64'(a) * 64'(b);
        return m[63:30];
    endfunction

    logic [3:0] vld_reg;

    logic signed [PW-1:0] p00_reg, p11_reg, p22_reg, p33_reg;
    logic signed [PW-1:0] p02_reg, p13_reg, p01_reg, p23_reg, p12_reg, p03_reg;

    logic signed [SW-1:0] s_reg, py_reg, px_reg, yy_reg, yx_reg;

    logic signed [30:0]    s_low;
    logic signed [61:0]    sq_full;
    qte_pkg::lanes_t       lanes3_reg, lanes4_reg;
    logic        [SQW-1:0] sq_reg, rem_reg;

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[2:0], ctl.vld};
        end
    end

    // Stage 1: all pairwise products.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            p00_reg <= mul_q30(quat_w, quat_w);
            p11_reg <= mul_q30(quat_x, quat_x);
            p22_reg <= mul_q30(quat_y, quat_y);
            p33_reg <= mul_q30(quat_z, quat_z);
            p02_reg <= mul_q30(quat_w, quat_y);
            p13_reg <= mul_q30(quat_x, quat_z);
            p01_reg <= mul_q30(quat_w, quat_x);
            p23_reg <= mul_q30(quat_y, quat_z);
            p12_reg <= mul_q30(quat_x, quat_y);
            p03_reg <= mul_q30(quat_w, quat_z);
        end
    end

    // Stage 2: doubled sums and differences, and diagonal combinations.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s_reg  <= (SW'(p02_reg) - SW'(p13_reg)) <<< 1;
            py_reg <= (SW'(p01_reg) + SW'(p23_reg)) <<< 1;
            px_reg <= SW'(p33_reg) - SW'(p22_reg) - SW'(p11_reg) + SW'(p00_reg);
            yy_reg <= (SW'(p12_reg) + SW'(p03_reg)) <<< 1;
            yx_reg <= SW'(p11_reg) + SW'(p00_reg) - SW'(p33_reg) - SW'(p22_reg);
        end
    end

    // Stage 3: square of the asin argument and its saturation flags.
    assign s_low   = s_reg[30:0];
    assign sq_full = 62'(s_low) * 62'(s_low);

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            sq_reg             <= sq_full[SQW-1:0];
            lanes3_reg.roll_y  <= s_reg;
            lanes3_reg.sat_pos <= (s_reg >= S_ONE);
            lanes3_reg.sat_neg <= (s_reg <= -S_ONE);
            lanes3_reg.pitch_y <= py_reg;
            lanes3_reg.pitch_x <= px_reg;
            lanes3_reg.yaw_y   <= yy_reg;
            lanes3_reg.yaw_x   <= yx_reg;
        end
    end

    // Stage 4: radicand of the cosine, one minus the square.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg    <= SQ_ONE - sq_reg;
            lanes4_reg <= lanes3_reg;
        end
    end

    assign vld   = vld_reg[3];
    assign lanes = lanes4_reg;
    assign rem   = rem_reg;

endmodule

`default_nettype wire

[hdl/qte_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on qte_pkg for widths and the stage count.
`default_nettype none

module qte_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qte_pkg::pipe_ctl_t            ctl,
    input  logic [qte_pkg::SQW-1:0]       rad,
    output logic                          vld,
    output logic [qte_pkg::RTW-1:0]       root
);

    localparam int SQW = qte_pkg::SQW;
    localparam int RW  = SQW + 1;
    localparam int N   = qte_pkg::SQ_STAGES;

    logic [N-1:0]   vld_reg;
    logic [SQW-1:0] n_reg [N];
    logic [RW-1:0]  r_reg [N];

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[N-2:0], ctl.vld};
        end
    end

    // Each stage tries the next bit pair of the root, starting from 4^30.
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - k));
        logic [SQW-1:0] n_in;
        logic [RW-1:0]  r_in;
        logic [RW-1:0]  trial;

        if (k == 0)
        begin : g_first
            assign n_in = rad;
            assign r_in = '0;
        end
        else
        begin : g_next
            assign n_in = n_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                if ({1'b0, n_in} >= trial)
                begin
                    n_reg[k] <= n_in - trial[SQW-1:0];
                    r_reg[k] <= (r_in >> 1) + BIT;
                end
                else
                begin
                    n_reg[k] <= n_in;
                    r_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    assign vld  = vld_reg[N-1];
    assign root = r_reg[N-1][qte_pkg::RTW-1:0];

endmodule

`default_nettype wire

[hdl/qte_cordic.sv]
// One atan2 lane: quadrant fold, unrolled vectoring CORDIC, radians to Q16 degrees.
// STAGES + 3 register stages; depends on qte_pkg.
`default_nettype none

module qte_cordic #(
    parameter int unsigned STAGES = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qte_pkg::pipe_ctl_t                ctl,
    input  logic signed [qte_pkg::SW-1:0]     y_in,
    input  logic signed [qte_pkg::SW-1:0]     x_in,
    output logic                              vld,
    output logic signed [qte_pkg::ANGW-1:0]   angle
);

    localparam int SW   = qte_pkg::SW;
    localparam int XYW  = qte_pkg::XYW;
    localparam int ZW   = qte_pkg::ZW;
    localparam int ANGW = qte_pkg::ANGW;
    localparam int LAT  = STAGES + 3;
    localparam int DW   = ANGW + 2;
    localparam logic signed [63:0] HALF_LSB = 64'sd137438953472;

    typedef enum logic [2:0] {
        AX_NONE,
        AX_ZERO,
        AX_HALF,
        AX_POS90,
        AX_NEG90
    } axis_t;

    logic [LAT-1:0] vld_reg;

    logic signed [XYW-1:0]  x_reg    [STAGES+1];
    logic signed [XYW-1:0]  y_reg    [STAGES+1];
    logic signed [ZW-1:0]   z_reg    [STAGES+1];
    axis_t                  axis_reg [STAGES+1];
    logic signed [ANGW-1:0] base_reg [STAGES+1];

    axis_t                  axis_next;
    logic signed [ANGW-1:0] base_next;
    logic signed [XYW-1:0]  x_ext, y_ext;

    logic signed [63:0]     prod_next, prod_reg;
    axis_t                  axis_m_reg;
    logic signed [ANGW-1:0] base_m_reg;

    logic signed [63:0]     rounded;
    logic signed [DW-1:0]   deg, total;
    logic signed [ANGW-1:0] angle_next, angle_reg;

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], ctl.vld};
        end
    end

    // Axis cases and the fold of the left half plane into the right.
    assign x_ext = XYW'(x_in);
    assign y_ext = XYW'(y_in);

    always_comb
    begin
        if (y_in == '0)
        begin
            axis_next = x_in[SW-1] ? AX_HALF : AX_ZERO;
        end
        else if (x_in == '0)
        begin
            axis_next = y_in[SW-1] ? AX_NEG90 : AX_POS90;
        end
        else
        begin
            axis_next = AX_NONE;
        end

        if (x_in[SW-1])
        begin
            base_next = y_in[SW-1] ? -qte_pkg::DEG180 : qte_pkg::DEG180;
        end
        else
        begin
            base_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            x_reg[0]    <= x_in[SW-1] ? -x_ext : x_ext;
            y_reg[0]    <= x_in[SW-1] ? -y_ext : y_ext;
            z_reg[0]    <= '0;
            axis_reg[0] <= axis_next;
            base_reg[0] <= base_next;
        end
    end

    // Vectoring iterations: rotate toward the x axis, accumulate the angle.
    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] STEP = ZW'(qte_pkg::atan_q30(5'(i)));
        logic signed [XYW-1:0] dx, dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                if (!y_reg[i][XYW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + STEP;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - STEP;
                end
                axis_reg[i+1] <= axis_reg[i];
                base_reg[i+1] <= base_reg[i];
            end
        end
    end

    // Scale by 180/pi in Q24.
    assign prod_next = 64'(z_reg[STAGES]) * 64'(qte_pkg::RAD2DEG_Q24);

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg   <= prod_next;
            axis_m_reg <= axis_reg[STAGES];
            base_m_reg <= base_reg[STAGES];
        end
    end

    // Round to Q16, add the half-plane offset, clamp and apply the axis cases.
    assign rounded = prod_reg + HALF_LSB;
    assign deg     = DW'($signed(rounded[63:38]));
    assign total   = DW'(base_m_reg) + deg;

    always_comb
    begin
        if (total > DW'(qte_pkg::DEG180))
        begin
            angle_next = qte_pkg::DEG180;
        end
        else if (total < -DW'(qte_pkg::DEG180))
        begin
            angle_next = -qte_pkg::DEG180;
        end
        else
        begin
            angle_next = total[ANGW-1:0];
        end

        case (axis_m_reg)
            AX_ZERO:  angle_next = '0;
            AX_HALF:  angle_next = qte_pkg::DEG180;
            AX_POS90: angle_next = qte_pkg::DEG90;
            AX_NEG90: angle_next = -qte_pkg::DEG90;
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign vld   = vld_reg[LAT-1];
    assign angle = angle_reg;

endmodule

`default_nettype wire

[hdl/quaternion_to_euler_angles.sv]
// Top level: quaternion in, roll/pitch/yaw in Q16 degrees out.
// Depends on qte_pkg, qte_if, qte_prod, qte_sqrt and qte_cordic.
//
//   Channel  Dir  Payload                                   Format
//   quat     in   quat_w, quat_x, quat_y, quat_z            signed Q30, 32 bits each
//   euler    out  roll_deg (24), pitch_deg (25), yaw_deg (25)  signed Q16 degrees
//
// The pipeline holds 4 product stages, 31 square root stages, CORDIC_STAGES + 3 angle
// stages and the output register. One item enters per cycle while the pipeline advances.
// Reset clears only the valid bits; the pipeline is ready right after reset.
// The pipeline keeps advancing while its last stage is empty, so items still enter
// while a result waits; it halts only when both the last stage and the output are full.
`default_nettype none

module quaternion_to_euler_angles #(
    parameter int unsigned CORDIC_STAGES = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    qte_in_if.sink     quat,
    qte_out_if.source  euler
);

    localparam int SQN    = qte_pkg::SQ_STAGES;
    localparam int ALAT   = CORDIC_STAGES + 3;
    localparam int SW     = qte_pkg::SW;
    localparam int ANGW   = qte_pkg::ANGW;
    localparam int ROLLW  = qte_pkg::ROLLW;

    logic pipe_en;
    logic out_load;
    logic v_last;

    logic                        prod_vld;
    qte_pkg::lanes_t             prod_lanes;
    logic [qte_pkg::SQW-1:0]     prod_rem;

    logic                        sqrt_vld;
    logic [qte_pkg::RTW-1:0]     sqrt_root;
    qte_pkg::lanes_t             lanes_dly_reg [SQN];
    qte_pkg::lanes_t             lanes_d;
    logic [1:0]                  sat_dly_reg [ALAT];

    logic                        roll_vld, pitch_vld, yaw_vld;
    logic signed [ANGW-1:0]      roll_ang, pitch_ang, yaw_ang;

    logic                        out_valid_reg;
    logic signed [ROLLW-1:0]     roll_next, roll_reg;
    logic signed [ANGW-1:0]      pitch_reg, yaw_reg;

    // Pipeline advance: last stage empty, or the output register can take it.
    assign out_load   = !out_valid_reg || euler.ready;
    assign pipe_en    = !v_last || out_load;
    assign quat.ready = pipe_en;
    assign v_last     = roll_vld;

    // Products and matrix terms.
    qte_prod u_prod (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    ('{en: pipe_en, vld: quat.valid}),
        .quat_w (quat.quat_w),
        .quat_x (quat.quat_x),
        .quat_y (quat.quat_y),
        .quat_z (quat.quat_z),
        .vld    (prod_vld),
        .lanes  (prod_lanes),
        .rem    (prod_rem)
    );

    // Cosine of the roll angle.
    qte_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{en: pipe_en, vld: prod_vld}),
        .rad   (prod_rem),
        .vld   (sqrt_vld),
        .root  (sqrt_root)
    );

    // Operands wait alongside the square root.
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            lanes_dly_reg[0] <= prod_lanes;
            for (int j = 1; j < SQN; j++)
            begin
                lanes_dly_reg[j] <= lanes_dly_reg[j-1];
            end
        end
    end

    assign lanes_d = lanes_dly_reg[SQN-1];

    // Saturation flags wait alongside the angle lanes.
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sat_dly_reg[0] <= {lanes_d.sat_pos, lanes_d.sat_neg};
            for (int j = 1; j < ALAT; j++)
            begin
                sat_dly_reg[j] <= sat_dly_reg[j-1];
            end
        end
    end

    // Three angle lanes.
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{en: pipe_en, vld: sqrt_vld}),
        .y_in  (lanes_d.roll_y),
        .x_in  ($signed(SW'(sqrt_root))),
        .vld   (roll_vld),
        .angle (roll_ang)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{en: pipe_en, vld: sqrt_vld}),
        .y_in  (lanes_d.pitch_y),
        .x_in  (lanes_d.pitch_x),
        .vld   (pitch_vld),
        .angle (pitch_ang)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{en: pipe_en, vld: sqrt_vld}),
        .y_in  (lanes_d.yaw_y),
        .x_in  (lanes_d.yaw_x),
        .vld   (yaw_vld),
        .angle (yaw_ang)
    );

    // Roll: saturation when the argument reaches one, else clamp to 90 degrees.
    always_comb
    begin
        if (sat_dly_reg[ALAT-1][1])
        begin
            roll_next = qte_pkg::ROLL_LIM;
        end
        else if (sat_dly_reg[ALAT-1][0])
        begin
            roll_next = -qte_pkg::ROLL_LIM;
        end
        else if (roll_ang > ANGW'(qte_pkg::ROLL_LIM))
        begin
            roll_next = qte_pkg::ROLL_LIM;
        end
        else if (roll_ang < -ANGW'(qte_pkg::ROLL_LIM))
        begin
            roll_next = -qte_pkg::ROLL_LIM;
        end
        else
        begin
            roll_next = roll_ang[ROLLW-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= v_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && v_last)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_ang;
            yaw_reg   <= yaw_ang;
        end
    end

    assign euler.valid     = out_valid_reg;
    assign euler.roll_deg  = roll_reg;
    assign euler.pitch_deg = pitch_reg;
    assign euler.yaw_deg   = yaw_reg;

    // The three lanes share one enable, so their valid bits never differ.
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_vld == roll_vld) && (yaw_vld == roll_vld))
        else $error("angle lanes out of step");

    // A halted pipeline keeps its last item.
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> v_last)
        else $error("item lost from last stage during a stall");

    // Roll never leaves plus or minus 90 degrees.
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.roll_deg <= qte_pkg::ROLL_LIM)
                     && (euler.roll_deg >= -qte_pkg::ROLL_LIM))
        else $error("roll out of range");

    // Pitch and yaw never leave plus or minus 180 degrees.
    a_atan_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.pitch_deg <= qte_pkg::DEG180)
                     && (euler.pitch_deg >= -qte_pkg::DEG180)
                     && (euler.yaw_deg <= qte_pkg::DEG180)
                     && (euler.yaw_deg >= -qte_pkg::DEG180))
        else $error("pitch or yaw out of range");

endmodule

`default_nettype wire

[verif/quaternion_to_euler_angles_tb.sv]
// Testbench for quaternion_to_euler_angles: directed and random quaternions checked
// against a bit-exact predictor of the roll, pitch and yaw angles.
// Depends on qte_pkg, qte_if and the RTL under hdl/.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_tb;

    localparam int STAGES      = 20;
    localparam int LATENCY     = STAGES + 39;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [qte_pkg::ROLLW-1:0] roll;
        logic signed [qte_pkg::ANGW-1:0]  pitch;
        logic signed [qte_pkg::ANGW-1:0]  yaw;
    } angles_t;

    logic clk;
    logic rst_n;

    qte_in_if  quat ();
    qte_out_if euler ();

    quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat.sink),
        .euler (euler.source)
    );

    angles_t pending_angles[$];
    int      mismatches;
    int      results_seen;
    int      items_sent;
    longint  cycles;
    bit      hold_off;
    bit      bursty;
    int      stall_pct;

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Arithmetic shift right (floor) on 64-bit signed values.
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        return floor_shift(a * b, 30);
    endfunction

    // atan(2^-i) in Q30 radians, from the alternating series.
    function automatic longint atan_q30_step(input int i);
        longint acc;
        longint term;
        int k;
        int sh;
        acc = 0;
        if (i == 0)
            return 64'sd843314857;
        for (k = 0; i * (2 * k + 1) <= 60; k++)
        begin
            sh = 60 - i * (2 * k + 1);
            term = longint'((64'd1 << sh) / longint'(2 * k + 1));
            acc += (k & 1) ? -term : term;
        end
        return (acc + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Vectoring CORDIC angle in Q16 degrees.
    function automatic longint atan2_q16(input longint y_in, input longint x_in);
        longint x, y, base, z, dx, dy, t, deg;
        int i;
        x = x_in;
        y = y_in;
        base = 0;
        z = 0;
        if (y == 0)
            return (x < 0) ? longint'(qte_pkg::DEG180) : 0;
        if (x == 0)
            return (y > 0) ? longint'(qte_pkg::DEG90) : -longint'(qte_pkg::DEG90);
        // Left half plane folds over to the right with a 180 degree offset.
        if (x < 0)
        begin
            base = (y >= 0) ? longint'(qte_pkg::DEG180) : -longint'(qte_pkg::DEG180);
            x = -x;
            y = -y;
        end
        for (i = 0; i < STAGES; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            t = atan_q30_step(i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += t;
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= t;
            end
        end
        deg = floor_shift(z * 64'sd961263669 + (64'sd1 << 37), 38);
        return clamp_sym(base + deg, longint'(qte_pkg::DEG180));
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n_in);
        longint unsigned n, res, b;
        n = n_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Expected angles for one quaternion.
    function automatic angles_t euler_from_quat(input logic signed [31:0] w,
                                                input logic signed [31:0] xi,
                                                input logic signed [31:0] yi,
                                                input logic signed [31:0] zi);
        longint q0, q1, q2, q3, s00, s11, s22, s33, s, r, p, yw;
        longint unsigned rem;
        angles_t a;
        q0 = w;
        q1 = xi;
        q2 = yi;
        q3 = zi;
        s00 = q30_product(q0, q0);
        s11 = q30_product(q1, q1);
        s22 = q30_product(q2, q2);
        s33 = q30_product(q3, q3);
        s = 2 * (q30_product(q0, q2) - q30_product(q1, q3));
        if (s >= Q30_ONE)
            r = qte_pkg::DEG90;
        else if (s <= -Q30_ONE)
            r = -longint'(qte_pkg::DEG90);
        else
        begin
            rem = (64'd1 << 60) - longint'(s * s);
            r = clamp_sym(atan2_q16(s, longint'(int_sqrt(rem))),
                          longint'(qte_pkg::DEG90));
        end
        p = atan2_q16(2 * (q30_product(q0, q1) + q30_product(q2, q3)),
                      s33 - s22 - s11 + s00);
        yw = atan2_q16(2 * (q30_product(q1, q2) + q30_product(q0, q3)),
                       s11 + s00 - s33 - s22);
        a.roll = r[qte_pkg::ROLLW-1:0];
        a.pitch = p[qte_pkg::ANGW-1:0];
        a.yaw = yw[qte_pkg::ANGW-1:0];
        return a;
    endfunction

    // Offer one quaternion and wait for it to be taken.
    task automatic send_quat(input logic signed [31:0] w, input logic signed [31:0] xi,
                             input logic signed [31:0] yi, input logic signed [31:0] zi);
        quat.valid  <= 1'b1;
        quat.quat_w <= w;
        quat.quat_x <= xi;
        quat.quat_y <= yi;
        quat.quat_z <= zi;
        pending_angles.push_back(euler_from_quat(w, xi, yi, zi));
        @(posedge clk);
        while (!quat.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Random gaps between bursts; valid drops only when a gap is taken.
    task automatic maybe_gap();
        int gap;
        if (bursty && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            quat.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_component();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sd1073741824 : -32'sd1073741824;
            1: return $urandom();
            2: return 32'sd0;
            default: return $signed($urandom_range(0, 32'h7fffffff)) - 32'sd1073741824;
        endcase
    endfunction

    // Random vector roughly on the unit sphere, scaled to Q30.
    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = $itor($signed($urandom())) / 2147483648.0;
        b = $itor($signed($urandom())) / 2147483648.0;
        c = $itor($signed($urandom())) / 2147483648.0;
        d = $itor($signed($urandom())) / 2147483648.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
        send_quat($rtoi(a / n * 1073741823.0), $rtoi(b / n * 1073741823.0),
                  $rtoi(c / n * 1073741823.0), $rtoi(d / n * 1073741823.0));
    endtask

    task automatic test_directed();
        localparam logic signed [31:0] ONE = 32'sd1073741824;
        localparam logic signed [31:0] HALF = 32'sd536870912;
        bursty = 1'b0;
        send_quat(0, 0, 0, 0);                       // zero quaternion
        send_quat(ONE, 0, 0, 0);                     // identity
        send_quat(-ONE, 0, 0, 0);
        send_quat(0, ONE, 0, 0);                     // negative x axis results
        send_quat(0, 0, ONE, 0);
        send_quat(0, 0, 0, ONE);
        send_quat(HALF, HALF, HALF, HALF);           // roll argument at zero
        send_quat(HALF, -HALF, HALF, HALF);          // roll saturates positive
        send_quat(HALF, HALF, -HALF, HALF);          // roll saturates negative
        send_quat(ONE, 0, ONE, 0);                   // far past the asin range
        send_quat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_quat(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_quat(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_quat(-ONE, -ONE, -ONE, -ONE);
        send_quat(1, 0, 0, 0);                       // products round to zero
        send_quat(-1, -1, -1, -1);
        send_quat(32'sd759250125, 32'sd759250125, 0, 0);
        send_quat(32'sd759250125, -32'sd759250125, 0, 0);
        send_quat(0, 0, 32'sd759250125, 32'sd759250125);
        send_quat(32'sd759250125, 0, 0, -32'sd759250125);
        send_quat(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
        quat.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_random_unit(input int count);
        bursty = 1'b1;
        repeat (count)
        begin
            send_unit_quat();
            maybe_gap();
        end
        quat.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_random_raw(input int count);
        bursty = 1'b1;
        repeat (count)
        begin
            send_quat(rand_component(), rand_component(), rand_component(),
                      rand_component());
            maybe_gap();
        end
        quat.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random_unit(150);
        join
    endtask

    // Full-rate stretch with no stalls on either side.
    task automatic test_full_rate();
        stall_pct = 0;
        bursty = 1'b0;
        repeat (200)
            send_unit_quat();
        quat.valid <= 1'b0;
        @(posedge clk);
        stall_pct = 25;
    endtask

    // Receiver ready pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            euler.ready <= 1'b0;
        else
            euler.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n && euler.valid && euler.ready)
        begin
            results_seen++;
            if (pending_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: roll %0d pitch %0d yaw %0d",
                             euler.roll_deg, euler.pitch_deg, euler.yaw_deg);
            end
            else
            begin
                want = pending_angles.pop_front();
                if (want.roll !== euler.roll_deg || want.pitch !== euler.pitch_deg
                    || want.yaw !== euler.yaw_deg)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at result %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 results_seen, want.roll, want.pitch, want.yaw,
                                 euler.roll_deg, euler.pitch_deg, euler.yaw_deg);
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        cycles = 0;
        hold_off = 1'b0;
        bursty = 1'b0;
        stall_pct = 25;
        quat.valid = 1'b0;
        quat.quat_w = '0;
        quat.quat_x = '0;
        quat.quat_y = '0;
        quat.quat_z = '0;
        @(posedge rst_n);
        @(posedge clk);
        test_directed();
        test_random_unit(700);
        test_backpressure();
        test_full_rate();
        test_random_raw(500);
        test_random_unit(280);
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d quaternions (directed, unit, raw 32-bit, back-pressure)",
                 items_sent);
        $display("Checked %0d angle results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
